>>> sv/substring_first_index_search_macros.svh
// Assertion macros for the substring first-index search block.
// Depends on nothing; included by files that carry concurrent checks.
`ifndef SUBSTRING_FIRST_INDEX_SEARCH_MACROS_SVH
`define SUBSTRING_FIRST_INDEX_SEARCH_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define SFIS_ASSERT_NOW(name, clk, rst_n, pre, post) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error("sfis check failed");

// Next-cycle implication, disabled while reset is asserted.
`define SFIS_ASSERT_NEXT(name, clk, rst_n, pre, post) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error("sfis check failed");

`endif

>>> sv/sfis_pkg.sv
// Shared sizes, command and error codes, and payload types of the substring search.
// Depends on nothing; imported by the compare cell and the top level.
`timescale 1ns / 1ps

package sfis_pkg;

    localparam int MAX_PATTERN = 32;
    localparam int MAX_TEXT    = 65536;
    localparam int TEXT_LIMIT  = (MAX_TEXT < 65536) ? MAX_TEXT : 65536;

    localparam int CH_W  = 18;
    localparam int POS_W = 16;
    localparam int LEN_W = $clog2(MAX_PATTERN + 1);
    localparam int TP_W  = $clog2(TEXT_LIMIT + 1);
    localparam int CMP_W = POS_W + 1;

    localparam logic [1:0] CMD_BEGIN   = 2'd0;
    localparam logic [1:0] CMD_PATTERN = 2'd1;
    localparam logic [1:0] CMD_TEXT    = 2'd2;

    localparam logic [1:0] ERR_NONE    = 2'd0;
    localparam logic [1:0] ERR_PATTERN = 2'd1;
    localparam logic [1:0] ERR_TEXT    = 2'd2;

    typedef struct packed {
        logic [1:0]       cmd;
        logic [CH_W-1:0]  ch;
        logic             last;
        logic [POS_W-1:0] start_offset;
    } in_t;

    typedef struct packed {
        logic             found;
        logic [POS_W-1:0] position;
        logic [1:0]       error;
    } out_t;

    // Controls broadcast to every compare cell.
    typedef struct packed {
        logic            step;
        logic            clear;
        logic [CH_W-1:0] ch;
    } cell_ctrl_t;

endpackage

>>> sv/substring_first_index_search.sv
// Substring first-index search: top level with control and a row of compare cells.
// Latency: a result appears on m_ the cycle after the last text character is transferred.
// Throughput: one item per cycle unless stalled; all cells compare each character at once.
// Reset (aresetn low, synchronous) clears the pattern length, offset, errors and text side.
// Depends on sfis_pkg, sfis_cell and substring_first_index_search_macros.svh.
`timescale 1ns / 1ps

`include "substring_first_index_search_macros.svh"

module substring_first_index_search
    import sfis_pkg::*;
(
    input  logic aclk,
    input  logic aresetn,
    input  logic s_valid,
    output logic s_ready,
    input  in_t  s_data,
    output logic m_valid,
    input  logic m_ready,
    output out_t m_data
);

    // Control state. The pattern characters live in the cells themselves.
    logic [LEN_W-1:0] len_reg,     len_next;
    logic [POS_W-1:0] offset_reg,  offset_next;
    logic [1:0]       err_reg,     err_next;
    logic [TP_W-1:0]  tp_reg,      tp_next;
    logic             hit_reg,     hit_next;
    logic [POS_W-1:0] hit_pos_reg, hit_pos_next;
    logic             m_valid_reg, m_valid_next;
    out_t             m_data_reg,  m_data_next;

    // Decoded transfer.
    logic s_xfer;
    logic is_begin;
    logic is_pattern;
    logic is_text;
    logic tp_full;
    logic text_ok;
    logic step;
    logic load_ok;
    logic res_valid;
    logic hit_now;
    logic full_match;
    logic [TP_W-1:0] start_pos;
    logic [1:0]      err_after;
    out_t            res;
    cell_ctrl_t      ctrl;

    // Per-cell signals of the compare row.
    logic [MAX_PATTERN-1:0] match_vec;
    logic [MAX_PATTERN-1:0] match_next_vec;
    logic [MAX_PATTERN-1:0] active_vec;
    logic [MAX_PATTERN-1:0] load_vec;
    logic [MAX_PATTERN-1:0] tail_vec;

    // The output register frees up in the same cycle that its result is
    // taken, so a new item may be transferred while a result waits.
    assign s_ready = !m_valid_reg || m_ready;
    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    always_comb begin
        s_xfer     = s_valid && s_ready;
        is_begin   = s_xfer && (s_data.cmd == CMD_BEGIN);
        is_pattern = s_xfer && (s_data.cmd == CMD_PATTERN);
        is_text    = s_xfer && (s_data.cmd == CMD_TEXT);
        // Characters beyond the position range are dropped and flagged.
        tp_full    = (tp_reg >= TP_W'(TEXT_LIMIT));
        text_ok    = is_text && !tp_full;
        step       = text_ok && (len_reg != '0);
        // Pattern characters are only taken before any text has arrived.
        load_ok    = is_pattern && (tp_reg == '0) && (len_reg < LEN_W'(MAX_PATTERN));
        res_valid  = is_text && s_data.last;

        ctrl.step  = step;
        ctrl.clear = is_begin || res_valid;
        ctrl.ch    = s_data.ch;
    end

    // Row of compare cells; each hands its match bit to the next cell.
    for (genvar j = 0; j < MAX_PATTERN; j++) begin : g_cell
        logic prev;

        if (j == 0) begin : g_first
            assign prev = 1'b1;
        end else begin : g_rest
            assign prev = match_vec[j-1];
        end

        assign active_vec[j] = (LEN_W'(j) < len_reg);
        assign load_vec[j]   = load_ok && (len_reg == LEN_W'(j));
        // The cell at the pattern's last character signals a full match.
        assign tail_vec[j]   = match_next_vec[j] && (len_reg == LEN_W'(j + 1));

        sfis_cell u_cell (
            .aclk       (aclk),
            .aresetn    (aresetn),
            .ctrl       (ctrl),
            .load       (load_vec[j]),
            .active     (active_vec[j]),
            .prev_match (prev),
            .match      (match_vec[j]),
            .match_next (match_next_vec[j])
        );
    end

    always_comb begin
        full_match = |tail_vec;
        // A full match ends at the current position, so it starts
        // one pattern length minus one earlier.
        start_pos  = tp_reg + TP_W'(1) - TP_W'(len_reg);
        hit_now    = step && !hit_reg && full_match
                     && (CMP_W'(start_pos) >= CMP_W'(offset_reg));

        err_after = err_reg;
        if (is_text && tp_full && (err_reg == ERR_NONE)) begin
            err_after = ERR_TEXT;
        end

        // Result of the transfer that carries the last text character.
        if (err_after != ERR_NONE) begin
            res.found    = 1'b0;
            res.position = '0;
            res.error    = err_after;
        end else if (len_reg == '0) begin
            res.found    = 1'b1;
            res.position = '0;
            res.error    = ERR_NONE;
        end else if (hit_reg) begin
            res.found    = 1'b1;
            res.position = hit_pos_reg;
            res.error    = ERR_NONE;
        end else if (hit_now) begin
            res.found    = 1'b1;
            res.position = POS_W'(start_pos);
            res.error    = ERR_NONE;
        end else begin
            res.found    = 1'b0;
            res.position = '0;
            res.error    = ERR_NONE;
        end
    end

    always_comb begin
        len_next     = len_reg;
        offset_next  = offset_reg;
        err_next     = err_reg;
        tp_next      = tp_reg;
        hit_next     = hit_reg;
        hit_pos_next = hit_pos_reg;
        m_valid_next = m_valid_reg;
        m_data_next  = m_data_reg;

        if (is_begin) begin
            len_next    = '0;
            offset_next = s_data.start_offset;
            err_next    = ERR_NONE;
            tp_next     = '0;
            hit_next    = 1'b0;
            hit_pos_next = '0;
        end

        if (is_pattern && (tp_reg == '0)) begin
            if (load_ok) begin
                len_next = len_reg + LEN_W'(1);
            end else if (err_reg == ERR_NONE) begin
                err_next = ERR_PATTERN;
            end
        end

        if (is_text) begin
            err_next = err_after;
            if (text_ok) begin
                tp_next = tp_reg + TP_W'(1);
            end
            if (hit_now) begin
                hit_next     = 1'b1;
                hit_pos_next = POS_W'(start_pos);
            end
            // After a result the text side is cleared; the pattern, the
            // offset and a pattern-too-long error are kept.
            if (s_data.last) begin
                tp_next      = '0;
                hit_next     = 1'b0;
                hit_pos_next = '0;
                if (err_after != ERR_PATTERN) begin
                    err_next = ERR_NONE;
                end
            end
        end

        if (s_ready) begin
            m_valid_next = res_valid;
            if (res_valid) begin
                m_data_next = res;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            len_reg     <= '0;
            offset_reg  <= '0;
            err_reg     <= ERR_NONE;
            tp_reg      <= '0;
            hit_reg     <= 1'b0;
            hit_pos_reg <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            len_reg     <= len_next;
            offset_reg  <= offset_next;
            err_reg     <= err_next;
            tp_reg      <= tp_next;
            hit_reg     <= hit_next;
            hit_pos_reg <= hit_pos_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_data_reg <= m_data_next;
    end

    // A result with an error never reports a match.
    `SFIS_ASSERT_NOW(a_err_no_found, aclk, aresetn, m_valid && (m_data.error != ERR_NONE), !m_data.found && (m_data.position == '0))
    // The last text character always leaves a result in the output register.
    `SFIS_ASSERT_NEXT(a_last_gives_result, aclk, aresetn, res_valid, m_valid)
    // Cells beyond the loaded pattern never hold a partial match.
    `SFIS_ASSERT_NOW(a_idle_cells_clear, aclk, aresetn, 1'b1, (match_vec & ~active_vec) == '0)
    // A recorded hit needs a non-empty pattern and some text.
    `SFIS_ASSERT_NOW(a_hit_needs_text, aclk, aresetn, hit_reg, (len_reg != '0) && (tp_reg != '0))

endmodule

>>> sv/sfis_cell.sv
// One compare cell: holds one pattern character and one partial-match bit.
// Depends on sfis_pkg; a row of these is instantiated by the top level.
`timescale 1ns / 1ps

module sfis_cell
    import sfis_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  cell_ctrl_t ctrl,
    input  logic       load,
    input  logic       active,
    input  logic       prev_match,
    output logic       match,
    output logic       match_next
);

    logic [CH_W-1:0] pat_reg;
    logic            match_reg;

    // The prefix ending here matches if the shorter prefix matched one
    // character earlier and this character agrees.
    assign match_next = prev_match && (pat_reg == ctrl.ch);
    assign match      = match_reg;

    always_ff @(posedge aclk) begin
        if (load) begin
            pat_reg <= ctrl.ch;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            match_reg <= 1'b0;
        end else if (ctrl.clear) begin
            match_reg <= 1'b0;
        end else if (ctrl.step && active) begin
            match_reg <= match_next;
        end
    end

endmodule
